[rtl/core/rcch_pkg.sv]
// Shared constants, codes and types of the RGB color cube histogram.
package rcch_pkg;

  localparam int IDX_W          = 12;
  localparam int CUBE_DEPTH     = 4096;
  localparam int K_W            = 5;
  localparam int Q_W            = 4;
  localparam int CHAN_W         = 8;
  localparam int FIELD_W        = 24;
  localparam int FRAC_W         = 17;
  localparam int FRAC_BITS      = 16;
  localparam int MAX_BINS       = 16;
  localparam int K_RESET        = 4;
  localparam int COUNT_WIDTH_DEF = 24;

  localparam logic [FRAC_W-1:0] FRAC_ONE = FRAC_W'(1 << FRAC_BITS);

  localparam logic [1:0] FUNC_ADD   = 2'd0;
  localparam logic [1:0] FUNC_READ  = 2'd1;
  localparam logic [1:0] FUNC_CLEAR = 2'd2;

  typedef struct packed {
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
  } mem_ctl_t;

endpackage

[rtl/core/rcch_bin_mem.sv]
// Bin counter memory: one write port and one read port with registered read data.
module rcch_bin_mem #(
  parameter int COUNT_WIDTH = rcch_pkg::COUNT_WIDTH_DEF
) (
  input  logic                   clk,
  input  rcch_pkg::mem_ctl_t     ctl,
  input  logic [COUNT_WIDTH-1:0] wr_data,
  output logic [COUNT_WIDTH-1:0] rd_data
);

  logic [COUNT_WIDTH-1:0] mem [rcch_pkg::CUBE_DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[ctl.wr_addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      rd_data <= mem[ctl.rd_addr];
    end
  end

endmodule

[rtl/core/rcch_index.sv]
// Three-stage pipeline that quantizes a pixel and forms its bin index.
module rcch_index (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [rcch_pkg::K_W-1:0]          k_eff,
  input  logic [rcch_pkg::CHAN_W-1:0]       red,
  input  logic [rcch_pkg::CHAN_W-1:0]       green,
  input  logic [rcch_pkg::CHAN_W-1:0]       blue,
  output logic                              idx_valid,
  output logic [rcch_pkg::IDX_W-1:0]        idx
);

  // A channel times k stays below 256 * 16, so the quantized value is the top nibble.
  localparam int PROD_W = rcch_pkg::CHAN_W + rcch_pkg::Q_W;
  localparam int YK_W   = rcch_pkg::Q_W + rcch_pkg::K_W;

  logic                      v1, v2;
  logic [rcch_pkg::Q_W-1:0]  qx, qy, qz, qx2;
  logic [YK_W-1:0]           yk, zk;
  logic [PROD_W-1:0]         px, py, pz;
  logic [rcch_pkg::IDX_W-1:0] zkk;

  assign px = PROD_W'(red)   * PROD_W'(k_eff);
  assign py = PROD_W'(green) * PROD_W'(k_eff);
  assign pz = PROD_W'(blue)  * PROD_W'(k_eff);
  assign zkk = rcch_pkg::IDX_W'(zk) * rcch_pkg::IDX_W'(k_eff);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      idx_valid <= 1'b0;
    end else begin
      v1        <= start;
      v2        <= v1;
      idx_valid <= v2;
    end
    qx  <= px[PROD_W-1 -: rcch_pkg::Q_W];
    qy  <= py[PROD_W-1 -: rcch_pkg::Q_W];
    qz  <= pz[PROD_W-1 -: rcch_pkg::Q_W];
    qx2 <= qx;
    yk  <= YK_W'(qy) * YK_W'(k_eff);
    zk  <= YK_W'(qz) * YK_W'(k_eff);
    idx <= rcch_pkg::IDX_W'(qx2) + rcch_pkg::IDX_W'(yk) + zkk;
  end

endmodule

[rtl/core/rcch_frac.sv]
// Restoring divider giving count / total in unsigned Q1.16, one quotient bit a cycle.
module rcch_frac #(
  parameter int COUNT_WIDTH = rcch_pkg::COUNT_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [COUNT_WIDTH-1:0]            count,
  input  logic [COUNT_WIDTH-1:0]            total,
  output logic                              done,
  output logic [rcch_pkg::FRAC_W-1:0]       frac
);

  localparam int STEP_W = $clog2(rcch_pkg::FRAC_BITS);

  logic                              busy;
  logic [STEP_W-1:0]                 step;
  logic [COUNT_WIDTH:0]              rmdr;
  logic [COUNT_WIDTH:0]              rmdr_sh;
  logic [COUNT_WIDTH-1:0]            dvsr;
  logic [rcch_pkg::FRAC_BITS-1:0]    quo;
  logic [rcch_pkg::FRAC_BITS-1:0]    quo_next;
  logic                              fits;

  // The remainder stays below the divisor, so the shifted value fits one extra bit.
  assign rmdr_sh  = {rmdr[COUNT_WIDTH-1:0], 1'b0};
  assign fits     = rmdr_sh >= {1'b0, dvsr};
  assign quo_next = {quo[rcch_pkg::FRAC_BITS-2:0], fits};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        step <= '0;
        quo  <= '0;
        rmdr <= {1'b0, count};
        dvsr <= total;
        if (total == '0) begin
          frac <= '0;
          done <= 1'b1;
        end else if (count >= total) begin
          frac <= rcch_pkg::FRAC_ONE;
          done <= 1'b1;
        end else begin
          busy <= 1'b1;
        end
      end else if (busy) begin
        rmdr <= fits ? rmdr_sh - {1'b0, dvsr} : rmdr_sh;
        quo  <= quo_next;
        step <= step + 1'b1;
        if (step == STEP_W'(rcch_pkg::FRAC_BITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
          frac <= {1'b0, quo_next};
        end
      end
    end
  end

endmodule

[rtl/core/rgb_color_cube_histogram_unit.sv]
// Top level of the RGB color cube histogram: control sequencer, total and result register.
//
// Usage: commands enter as words on the item channel (item_valid / item_ready) with
// func selecting add pixel, read bin or clear. Each command gives exactly one result
// word on the result channel (result_valid / result_ready) carrying bin_index,
// bin_count, fraction and total_pixels. The bin count k is written through
// cfg_write / cfg_data; the user must write it only while the block is idle (the
// block does not enforce this), and it takes effect on the next pixel. The block
// handles one command at a time. An add's result passes through the three index
// stages, the registered memory read and the 16-step fraction divider; a read's skips
// the index stages. A new command is taken only after the previous result is loaded
// into the output register. When the total is zero or the count is at least the
// total, the divider skips its steps and answers directly. An unused code goes
// straight to the output register. A clear walks all 4096 bins, one per cycle, before
// its result is given. After reset the same walk runs with item_ready low;
// configuration writes are taken throughout.
// A finished result sits in the output register until taken; the next command is
// accepted meanwhile, but its own result waits until the register is free.
module rgb_color_cube_histogram_unit #(
  parameter int COUNT_WIDTH = rcch_pkg::COUNT_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [rcch_pkg::K_W-1:0]          cfg_data,
  input  logic                              item_valid,
  output logic                              item_ready,
  input  logic [1:0]                        func,
  input  logic [rcch_pkg::CHAN_W-1:0]       red,
  input  logic [rcch_pkg::CHAN_W-1:0]       green,
  input  logic [rcch_pkg::CHAN_W-1:0]       blue,
  input  logic [rcch_pkg::IDX_W-1:0]        read_index,
  output logic                              result_valid,
  input  logic                              result_ready,
  output logic [rcch_pkg::IDX_W-1:0]        bin_index,
  output logic [rcch_pkg::FIELD_W-1:0]      bin_count,
  output logic [rcch_pkg::FRAC_W-1:0]       fraction,
  output logic [rcch_pkg::FIELD_W-1:0]      total_pixels
);

  typedef enum logic [2:0] {
    S_SWEEP, S_IDLE, S_INDEX, S_RDWAIT, S_FRAC, S_OUT
  } state_t;

  state_t                         state;
  logic [1:0]                     func_q;
  logic [rcch_pkg::IDX_W-1:0]     sweep_addr;
  logic                           sweep_reply;
  logic [rcch_pkg::IDX_W-1:0]     res_idx;
  logic [COUNT_WIDTH-1:0]         cnt_q;
  logic [COUNT_WIDTH-1:0]         total;
  logic [rcch_pkg::FRAC_W-1:0]    frac_q;
  logic [rcch_pkg::K_W-1:0]       bins_per_channel;
  logic [rcch_pkg::K_W-1:0]       k_eff;

  logic                           accept;
  logic                           out_load;
  logic                           idx_valid;
  logic [rcch_pkg::IDX_W-1:0]     idx_out;
  rcch_pkg::mem_ctl_t             mem_ctl;
  logic [COUNT_WIDTH-1:0]         mem_wdata;
  logic [COUNT_WIDTH-1:0]         mem_rdata;
  logic [COUNT_WIDTH-1:0]         cnt_inc;
  logic [COUNT_WIDTH-1:0]         total_inc;
  logic [COUNT_WIDTH-1:0]         div_count;
  logic [COUNT_WIDTH-1:0]         div_total;
  logic                           div_start;
  logic                           div_done;
  logic [rcch_pkg::FRAC_W-1:0]    div_frac;

  assign item_ready = (state == S_IDLE);
  assign accept     = item_valid && item_ready;
  assign out_load   = (state == S_OUT) && (!result_valid || result_ready);

  always_comb begin
    if (bins_per_channel == '0) begin
      k_eff = rcch_pkg::K_W'(1);
    end else if (bins_per_channel > rcch_pkg::K_W'(rcch_pkg::MAX_BINS)) begin
      k_eff = rcch_pkg::K_W'(rcch_pkg::MAX_BINS);
    end else begin
      k_eff = bins_per_channel;
    end
  end

  assign cnt_inc   = (mem_rdata == '1) ? mem_rdata : mem_rdata + 1'b1;
  assign total_inc = (total == '1) ? total : total + 1'b1;

  always_comb begin
    mem_ctl.rd_en   = (accept && func == rcch_pkg::FUNC_READ) ||
                      (state == S_INDEX && idx_valid);
    mem_ctl.rd_addr = (state == S_IDLE) ? read_index : idx_out;
    mem_ctl.wr_en   = (state == S_SWEEP) ||
                      (state == S_RDWAIT && func_q == rcch_pkg::FUNC_ADD);
    mem_ctl.wr_addr = (state == S_SWEEP) ? sweep_addr : res_idx;
    mem_wdata       = (state == S_SWEEP) ? '0 : cnt_inc;
  end

  assign div_start = (state == S_RDWAIT);
  assign div_count = (func_q == rcch_pkg::FUNC_ADD) ? cnt_inc : mem_rdata;
  assign div_total = (func_q == rcch_pkg::FUNC_ADD) ? total_inc : total;

  rcch_index u_index (
    .clk       (clk),
    .rst       (rst),
    .start     (accept && func == rcch_pkg::FUNC_ADD),
    .k_eff     (k_eff),
    .red       (red),
    .green     (green),
    .blue      (blue),
    .idx_valid (idx_valid),
    .idx       (idx_out)
  );

  rcch_bin_mem #(.COUNT_WIDTH(COUNT_WIDTH)) u_mem (
    .clk     (clk),
    .ctl     (mem_ctl),
    .wr_data (mem_wdata),
    .rd_data (mem_rdata)
  );

  rcch_frac #(.COUNT_WIDTH(COUNT_WIDTH)) u_frac (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .count (div_count),
    .total (div_total),
    .done  (div_done),
    .frac  (div_frac)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_SWEEP;
      sweep_addr       <= '0;
      sweep_reply      <= 1'b0;
      total            <= '0;
      result_valid     <= 1'b0;
      bins_per_channel <= rcch_pkg::K_W'(rcch_pkg::K_RESET);
    end else begin
      if (cfg_write) begin
        bins_per_channel <= cfg_data;
      end
      if (out_load) begin
        result_valid <= 1'b1;
      end else if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_SWEEP: begin
          sweep_addr <= sweep_addr + 1'b1;
          if (sweep_addr == rcch_pkg::IDX_W'(rcch_pkg::CUBE_DEPTH - 1)) begin
            state <= sweep_reply ? S_OUT : S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            func_q <= func;
            unique case (func)
              rcch_pkg::FUNC_ADD: begin
                state <= S_INDEX;
              end
              rcch_pkg::FUNC_READ: begin
                res_idx <= read_index;
                state   <= S_RDWAIT;
              end
              rcch_pkg::FUNC_CLEAR: begin
                res_idx     <= '0;
                cnt_q       <= '0;
                frac_q      <= '0;
                total       <= '0;
                sweep_addr  <= '0;
                sweep_reply <= 1'b1;
                state       <= S_SWEEP;
              end
              default: begin
                // Unused code: nothing changes, the current total is reported.
                res_idx <= '0;
                cnt_q   <= '0;
                frac_q  <= '0;
                state   <= S_OUT;
              end
            endcase
          end
        end
        S_INDEX: begin
          if (idx_valid) begin
            res_idx <= idx_out;
            state   <= S_RDWAIT;
          end
        end
        S_RDWAIT: begin
          cnt_q <= div_count;
          total <= div_total;
          state <= S_FRAC;
        end
        S_FRAC: begin
          if (div_done) begin
            frac_q <= div_frac;
            state  <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_load) begin
            bin_index    <= res_idx;
            bin_count    <= rcch_pkg::FIELD_W'(cnt_q);
            fraction     <= frac_q;
            total_pixels <= rcch_pkg::FIELD_W'(total);
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
